### sv/gnm_pkg.sv
// shared types and constants for the glob name matcher
// used by glob_name_matcher and gnm_checker, no dependencies
package gnm_pkg;

  localparam int PATTERN_CHARS_DEF = 32;
  localparam int PATTERN_CHARS_MAX = 64;

  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 6;
  localparam int WORD_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CHARS_PER_ROW = WORD_W / CHAR_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_3 = 3'd4;

  // pattern metacharacters
  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_QMARK     = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_STAR      = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_LBRACK    = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_BANG      = 8'h21;
  localparam logic [CHAR_W-1:0] CH_DASH      = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_RBRACK    = 8'h5D;

  typedef enum logic [1:0] {
    VERDICT_OPEN  = 2'd0,
    VERDICT_FAIL  = 2'd1,
    VERDICT_MATCH = 2'd2,
    VERDICT_SUPER = 2'd3
  } verdict_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_ELEM,
    ST_ESC_CHK,
    ST_STAR2,
    ST_CLS,
    ST_CLS_HI,
    ST_CLS_END,
    ST_FINISH,
    ST_TRAIL,
    ST_TRAIL_CHK,
    ST_OUT
  } state_t;

  // output word: bit 0 is_match, bit 1 is_supermatch
  localparam int OUT_MATCH_BIT = 0;
  localparam int OUT_SUPER_BIT = 1;

endpackage

### sv/glob_name_matcher.sv
// glob pattern matcher, one name character per input word
// depends on gnm_pkg; gnm_checker is bound to it from its own file
// a word is taken only in the idle state, once the previous word is fully handled:
// an escape reads the escaped character, a '*' looks ahead for '**' or starts a search,
// a class walks each class character and reads the upper bound of each range, and the
// last word walks any trailing '*' and waits until the result word loads, so a stalled
// result word holds off the input
// reset clears control state, the pattern length and the row valid bits; unwritten pattern rows read as zero
module glob_name_matcher #(
  parameter int PATTERN_CHARS = gnm_pkg::PATTERN_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // name stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] name_char
  input  logic        s_tlast,   // end_of_name
  input  logic [0:0]  s_tuser,   // [0] no_char
  // verdict stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] is_match, [1] is_supermatch, [7:2] zero
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // position width holds 0..PATTERN_CHARS
  localparam int PW   = $clog2(PATTERN_CHARS + 1);
  localparam int ROWS = (PATTERN_CHARS + gnm_pkg::CHARS_PER_ROW - 1) / gnm_pkg::CHARS_PER_ROW;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SW   = $clog2(gnm_pkg::CHARS_PER_ROW);

  // pattern memory: one row holds eight characters, as written by one config word
  logic [gnm_pkg::WORD_W-1:0] mem [ROWS];
  logic [ROWS-1:0]            row_valid;
  logic [gnm_pkg::LEN_W-1:0]  pattern_length;

  logic [gnm_pkg::CFG_IDX_W-1:0] wr_idx;
  logic                          wr_row_en;

  assign wr_idx    = cfg_index - gnm_pkg::CFG_WORD_0;
  assign wr_row_en = cfg_we && (cfg_index >= gnm_pkg::CFG_WORD_0) &&
                     (cfg_index <= gnm_pkg::CFG_WORD_3) && (32'(wr_idx) < ROWS);

  always_ff @(posedge clk) begin
    if (wr_row_en) begin
      mem[RW'(wr_idx)] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid      <= '0;
      pattern_length <= '0;
    end else if (cfg_we) begin
      if (cfg_index == gnm_pkg::CFG_LENGTH) begin
        pattern_length <= cfg_data[gnm_pkg::LEN_W-1:0];
      end
      if (wr_row_en) begin
        row_valid[RW'(wr_idx)] <= 1'b1;
      end
    end
  end

  // effective length, clamped to the memory size
  logic [6:0]    len7;
  logic [6:0]    lim7;
  logic [PW-1:0] len_eff;
  logic [PW:0]   len_x;

  assign len7    = {1'b0, pattern_length};
  assign lim7    = 7'(PATTERN_CHARS);
  assign len_eff = PW'((len7 > lim7) ? lim7 : len7);
  assign len_x   = {1'b0, len_eff};

  // read port, data registered and ready in the cycle after the address
  logic                       rd_en;
  logic [PW-1:0]              rd_addr;
  logic [gnm_pkg::WORD_W-1:0] rd_row_q;
  logic [SW-1:0]              rd_sel_q;
  logic                       rd_valid_q;
  logic [7:0]                 pd;
  logic [RW-1:0]              rd_row;

  assign rd_row = RW'(rd_addr >> SW);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_q   <= mem[rd_row];
      rd_sel_q   <= rd_addr[SW-1:0];
      rd_valid_q <= row_valid[rd_row];
    end
  end

  // a row never written reads as zero, like the cleared pattern after reset
  assign pd = rd_valid_q ? rd_row_q[rd_sel_q*8 +: 8] : 8'h00;

  // matcher state
  gnm_pkg::state_t   state, state_next;
  gnm_pkg::verdict_t verdict, verdict_next;
  logic [PW-1:0]     pos, pos_next;
  logic              star, star_next;
  logic [7:0]        cur_char;
  logic              cur_last;
  logic              cur_none;
  // class walk
  logic [PW-1:0]     g, g_next;
  logic              inv, inv_next;
  logic              matched, matched_next;
  logic              have_prev, have_prev_next;
  logic [7:0]        prev, prev_next;
  logic              cls_first, cls_first_next;

  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic [PW:0]       pos_p1;
  logic [PW:0]       pos_p2;
  logic [PW:0]       g_p1;
  logic [PW:0]       g_p2;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == gnm_pkg::ST_OUT) && out_free;
  assign pos_p1   = {1'b0, pos} + (PW+1)'(1);
  assign pos_p2   = {1'b0, pos} + (PW+1)'(2);
  assign g_p1     = {1'b0, g} + (PW+1)'(1);
  assign g_p2     = {1'b0, g} + (PW+1)'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gnm_pkg::ST_IDLE;
      verdict   <= gnm_pkg::VERDICT_OPEN;
      pos       <= '0;
      star      <= 1'b0;
      cur_last  <= 1'b0;
      cur_none  <= 1'b0;
      inv       <= 1'b0;
      matched   <= 1'b0;
      have_prev <= 1'b0;
      cls_first <= 1'b0;
      g         <= '0;
    end else begin
      state     <= state_next;
      verdict   <= verdict_next;
      pos       <= pos_next;
      star      <= star_next;
      inv       <= inv_next;
      matched   <= matched_next;
      have_prev <= have_prev_next;
      cls_first <= cls_first_next;
      g         <= g_next;
      if (in_fire) begin
        cur_last <= s_tlast;
        cur_none <= s_tuser[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prev <= prev_next;
    if (in_fire) begin
      cur_char <= s_tdata;
    end
  end

  // next state and datapath
  logic        cls_go;
  logic [PW:0] cls_ng;
  logic        elem_go;

  always_comb begin
    state_next     = state;
    verdict_next   = verdict;
    pos_next       = pos;
    star_next      = star;
    g_next         = g;
    inv_next       = inv;
    matched_next   = matched;
    have_prev_next = have_prev;
    prev_next      = prev;
    cls_first_next = cls_first;
    rd_en          = 1'b0;
    rd_addr        = pos;
    cls_go         = 1'b0;
    cls_ng         = g_p1;
    elem_go        = 1'b0;

    case (state)
      gnm_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = gnm_pkg::ST_BEGIN;
        end
      end

      gnm_pkg::ST_BEGIN: begin
        if (cur_none || verdict != gnm_pkg::VERDICT_OPEN) begin
          state_next = gnm_pkg::ST_FINISH;
        end else if ({1'b0, pos} < len_x) begin
          rd_en      = 1'b1;
          rd_addr    = pos;
          state_next = gnm_pkg::ST_ELEM;
        end else begin
          // a star search with no pattern left keeps searching, else the name is too long
          if (!star) begin
            verdict_next = gnm_pkg::VERDICT_FAIL;
          end
          state_next = gnm_pkg::ST_FINISH;
        end
      end

      gnm_pkg::ST_ELEM: begin
        state_next = gnm_pkg::ST_FINISH;
        if (star) begin
          if (pd == cur_char) begin
            star_next = 1'b0;
            elem_go   = 1'b1;
          end
        end else begin
          elem_go = 1'b1;
        end
        if (elem_go) begin
          case (pd)
            gnm_pkg::CH_BACKSLASH: begin
              if (pos_p1 < len_x) begin
                rd_en      = 1'b1;
                rd_addr    = pos_p1[PW-1:0];
                state_next = gnm_pkg::ST_ESC_CHK;
              end else begin
                verdict_next = gnm_pkg::VERDICT_FAIL;
              end
            end
            gnm_pkg::CH_QMARK: begin
              pos_next = pos_p1[PW-1:0];
            end
            gnm_pkg::CH_STAR: begin
              if (pos_p1 < len_x) begin
                rd_en      = 1'b1;
                rd_addr    = pos_p1[PW-1:0];
                state_next = gnm_pkg::ST_STAR2;
              end else begin
                verdict_next = gnm_pkg::VERDICT_MATCH;
              end
            end
            gnm_pkg::CH_LBRACK: begin
              g_next         = pos_p1[PW-1:0];
              inv_next       = 1'b0;
              matched_next   = 1'b0;
              have_prev_next = 1'b0;
              cls_first_next = 1'b1;
              if (pos_p1 < len_x) begin
                rd_en      = 1'b1;
                rd_addr    = pos_p1[PW-1:0];
                state_next = gnm_pkg::ST_CLS;
              end else begin
                state_next = gnm_pkg::ST_CLS_END;
              end
            end
            default: begin
              if (pd == cur_char) begin
                pos_next = pos_p1[PW-1:0];
              end else begin
                verdict_next = gnm_pkg::VERDICT_FAIL;
              end
            end
          endcase
        end
      end

      gnm_pkg::ST_ESC_CHK: begin
        if (pd == cur_char) begin
          pos_next = pos_p2[PW-1:0];
        end else begin
          verdict_next = gnm_pkg::VERDICT_FAIL;
        end
        state_next = gnm_pkg::ST_FINISH;
      end

      gnm_pkg::ST_STAR2: begin
        if (pd == gnm_pkg::CH_STAR) begin
          verdict_next = gnm_pkg::VERDICT_SUPER;
          state_next   = gnm_pkg::ST_FINISH;
        end else begin
          // start the search on the character after the star
          pos_next   = pos_p1[PW-1:0];
          star_next  = 1'b1;
          state_next = gnm_pkg::ST_BEGIN;
        end
      end

      gnm_pkg::ST_CLS: begin
        cls_first_next = 1'b0;
        if (cls_first && pd == gnm_pkg::CH_BANG) begin
          inv_next = 1'b1;
          cls_go   = 1'b1;
          cls_ng   = g_p1;
        end else if (pd == gnm_pkg::CH_RBRACK) begin
          state_next = gnm_pkg::ST_CLS_END;
        end else if (pd == gnm_pkg::CH_DASH && have_prev && g_p1 < len_x) begin
          // possible range, look at the upper bound
          rd_en      = 1'b1;
          rd_addr    = g_p1[PW-1:0];
          state_next = gnm_pkg::ST_CLS_HI;
        end else begin
          if (pd == cur_char) begin
            matched_next = 1'b1;
          end
          prev_next      = pd;
          have_prev_next = 1'b1;
          cls_go         = 1'b1;
          cls_ng         = g_p1;
        end
      end

      gnm_pkg::ST_CLS_HI: begin
        if (pd != gnm_pkg::CH_RBRACK) begin
          if (cur_char >= prev && cur_char <= pd) begin
            matched_next = 1'b1;
          end
          have_prev_next = 1'b0;
          cls_ng         = g_p2;
        end else begin
          // dash right before the closing bracket is literal
          if (cur_char == gnm_pkg::CH_DASH) begin
            matched_next = 1'b1;
          end
          prev_next      = gnm_pkg::CH_DASH;
          have_prev_next = 1'b1;
          cls_ng         = g_p1;
        end
        cls_go = 1'b1;
      end

      gnm_pkg::ST_CLS_END: begin
        if (matched != inv) begin
          pos_next = ({1'b0, g} < len_x) ? g_p1[PW-1:0] : g;
        end else begin
          verdict_next = gnm_pkg::VERDICT_FAIL;
        end
        state_next = gnm_pkg::ST_FINISH;
      end

      gnm_pkg::ST_FINISH: begin
        if (!cur_last) begin
          state_next = gnm_pkg::ST_IDLE;
        end else if (verdict != gnm_pkg::VERDICT_OPEN) begin
          state_next = gnm_pkg::ST_OUT;
        end else if (star) begin
          verdict_next = gnm_pkg::VERDICT_FAIL;
          state_next   = gnm_pkg::ST_OUT;
        end else begin
          state_next = gnm_pkg::ST_TRAIL;
        end
      end

      gnm_pkg::ST_TRAIL: begin
        if ({1'b0, pos} < len_x) begin
          rd_en      = 1'b1;
          rd_addr    = pos;
          state_next = gnm_pkg::ST_TRAIL_CHK;
        end else begin
          verdict_next = gnm_pkg::VERDICT_MATCH;
          state_next   = gnm_pkg::ST_OUT;
        end
      end

      gnm_pkg::ST_TRAIL_CHK: begin
        if (pd == gnm_pkg::CH_STAR) begin
          pos_next   = pos_p1[PW-1:0];
          state_next = gnm_pkg::ST_TRAIL;
        end else begin
          verdict_next = gnm_pkg::VERDICT_FAIL;
          state_next   = gnm_pkg::ST_OUT;
        end
      end

      gnm_pkg::ST_OUT: begin
        if (out_free) begin
          verdict_next = gnm_pkg::VERDICT_OPEN;
          pos_next     = '0;
          star_next    = 1'b0;
          state_next   = gnm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = gnm_pkg::ST_IDLE;
      end
    endcase

    // step the class walk to the next character or close it at the pattern end
    if (cls_go) begin
      g_next = cls_ng[PW-1:0];
      if (cls_ng < len_x) begin
        rd_en      = 1'b1;
        rd_addr    = cls_ng[PW-1:0];
        state_next = gnm_pkg::ST_CLS;
      end else begin
        state_next = gnm_pkg::ST_CLS_END;
      end
    end
  end

  // handshake outputs
  always_comb begin
    s_tready = (state == gnm_pkg::ST_IDLE);
  end

  // result register, parts the matcher from the consumer
  logic [7:0] out_word;

  always_comb begin
    out_word                        = '0;
    out_word[gnm_pkg::OUT_MATCH_BIT] = (verdict == gnm_pkg::VERDICT_MATCH) ||
                                       (verdict == gnm_pkg::VERDICT_SUPER);
    out_word[gnm_pkg::OUT_SUPER_BIT] = (verdict == gnm_pkg::VERDICT_SUPER);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_word;
    end
  end

endmodule

### sv/gnm_checker.sv
// port-level checks for glob_name_matcher, attached by bind
// depends on gnm_pkg and the ports of glob_name_matcher
module gnm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // no result word right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result word changed while stalled");

  // supermatch always comes with match, padding stays zero
  a_super: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[gnm_pkg::OUT_MATCH_BIT] || !m_tdata[gnm_pkg::OUT_SUPER_BIT]) &&
                  (m_tdata[7:2] == 6'd0)))
    else $error("bad result word");

  // only one name character is in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word taken while busy");

  // a word that does not end a name raises no result
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tlast) |=> !$rose(m_tvalid))
    else $error("result without end of name");

endmodule

bind glob_name_matcher gnm_checker u_gnm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
